// ===== rtl/core/tla_pkg.sv =====
// shared types and constants for the trimmed latency averager
// no dependencies
package tla_pkg;

   localparam int CHANNELS_DEF = 2;
   localparam int TRIM_DEF     = 5;
   localparam int WARMUP_DEF   = 10;

   localparam int TS_W  = 32;
   localparam int WIN_W = 20;
   localparam int D_W   = 21;
   localparam int SUM_W = 40;
   localparam int CNT_W = 16;
   localparam int ST_W  = 3;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 20'd500000;
   localparam logic [CNT_W-1:0] COUNT_MAX    = 16'hFFFF;

   localparam logic [ST_W-1:0] ST_ARMED  = 3'd0;
   localparam logic [ST_W-1:0] ST_AVG    = 3'd1;
   localparam logic [ST_W-1:0] ST_NOARM  = 3'd2;
   localparam logic [ST_W-1:0] ST_OUTWIN = 3'd3;
   localparam logic [ST_W-1:0] ST_WARM   = 3'd4;
   localparam logic [ST_W-1:0] ST_SAT    = 3'd5;

   localparam logic KIND_REF = 1'b0;

   typedef logic signed [D_W-1:0] delta_type;

endpackage

// ===== rtl/core/trimmed_latency_average_top.sv =====
// trimmed latency averager: top level with its sequencer and datapath
// depends on tla_pkg and tla_ram
//
// Usage: one event is taken on the req_ channel per transfer (reference or
// measurement, bank select, channel, timestamp). Each event makes exactly one
// result on the rsp_ channel. The window register is written through
// csr_wr_en / csr_wr_data; write it only while the block is idle, the block
// itself does not enforce this. Reference events and out-of-range channels
// go straight to the done state. Measurements pass through the slot lookup,
// the mean division and the load of the output register. The last warmup
// delta of a slot adds a load pass and a ranking pass to sort the warmup
// store from its ram. One event is in work at a time, so a new one is taken
// only once the sequencer is back in idle; req_ready is high whenever it is
// idle, including while the previous result waits in the output register.
// A result that finds the output register full waits until rsp_ready frees it.
// Reset: the window returns to 500000, all channels are disarmed, slot state
// reads as fresh through per-slot touched bits; no clearing pass is needed.
// Per-slot state lives in a slot ram, the extreme sets in a set ram and the
// warmup deltas in a store ram.
module trimmed_latency_average_top
   import tla_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF,
   parameter int TRIM     = TRIM_DEF,
   parameter int WARMUP   = WARMUP_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  logic                   req_edge_req,
   input  logic                   req_channel,
   input  logic [TS_W-1:0]        req_timestamp_us,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ST_W-1:0]        rsp_status,
   output logic signed [D_W-1:0]  rsp_delta_us,
   output logic signed [D_W-1:0]  rsp_kept_value_us,
   output logic signed [D_W-1:0]  rsp_mean_us,
   output logic [CNT_W-1:0]       rsp_sample_count,
   input  logic                   csr_wr_en,
   input  logic [WIN_W-1:0]       csr_wr_data
);
   localparam int SLOTS    = 2 * CHANNELS;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int WL_W     = $clog2(WARMUP + 1);
   localparam int STORE_D  = SLOTS * WARMUP;
   localparam int STORE_AW = $clog2(STORE_D);
   localparam int IDX_W    = $clog2(WARMUP);
   localparam int SET_W    = 2 * TRIM * D_W;
   localparam int ROW_W    = WL_W + SUM_W + CNT_W;
   localparam int DIV_STEPS = SUM_W;
   localparam int STEP_W   = $clog2(DIV_STEPS + WARMUP + 1);
   localparam int REM_W    = CNT_W + 1;
   localparam logic signed [D_W-1:0] D_MAX = {1'b0, {(D_W-1){1'b1}}};
   localparam logic signed [D_W-1:0] D_MIN = {1'b1, {(D_W-1){1'b0}}};

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_LOOK = 6'b000010,
      S_LOAD = 6'b000100,
      S_RANK = 6'b001000,
      S_DIV  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [WIN_W-1:0]  window_ff;
   logic [TS_W-1:0]   ref_ff [2];
   logic [SLOTS-1:0]  armed_ff, touched_ff;
   logic              bank_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [TS_W-1:0]   ts_ff;
   logic [ST_W-1:0]   status_ff;
   delta_type         delta_ff, kept_ff, mean_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0]  cnt_ff;
   delta_type         mx_ff [TRIM];
   delta_type         mn_ff [TRIM];
   delta_type         mx_in [TRIM];
   delta_type         mn_in [TRIM];
   delta_type         shv_ff [WARMUP];
   logic [IDX_W-1:0]  shi_ff [WARMUP];
   logic [STEP_W-1:0] step_ff;
   logic [REM_W+SUM_W-1:0] div_ff;
   logic              neg_ff;

   // ram ports
   logic              slot_we;
   logic [ROW_W-1:0]  slot_wdata, slot_rdata, row;
   logic              set_we;
   logic [SET_W-1:0]  set_wdata, set_rdata;
   logic              store_we;
   logic [STORE_AW-1:0] store_waddr, store_raddr;
   delta_type         store_wdata, store_rdata;
   logic [SLOT_W-1:0] slot_sel;

   logic [SLOT_W-1:0] req_slot;
   logic              req_chan_ok;
   logic              req_fire;

   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign req_slot    = SLOT_W'(int'(req_edge_req) * CHANNELS + int'(req_channel));
   assign req_chan_ok = int'(req_channel) < CHANNELS;
   assign slot_sel    = (state_ff == S_IDLE) ? req_slot : slot_ff;

   tla_ram #(.WIDTH(ROW_W), .DEPTH(SLOTS)) u_slot_ram (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_ff), .wr_data(slot_wdata),
      .rd_addr(slot_sel), .rd_data(slot_rdata));

   tla_ram #(.WIDTH(SET_W), .DEPTH(SLOTS)) u_set_ram (
      .clock(clock), .wr_en(set_we), .wr_addr(slot_ff), .wr_data(set_wdata),
      .rd_addr(slot_sel), .rd_data(set_rdata));

   tla_ram #(.WIDTH(D_W), .DEPTH(STORE_D)) u_store_ram (
      .clock(clock), .wr_en(store_we), .wr_addr(store_waddr), .wr_data(store_wdata),
      .rd_addr(store_raddr), .rd_data(store_rdata));

   // untouched slots read as their reset contents
   assign row = touched_ff[slot_ff] ? slot_rdata
                                    : {WL_W'(WARMUP), {SUM_W{1'b0}}, {CNT_W{1'b0}}};

   logic [WL_W-1:0]         row_wl;
   logic signed [SUM_W-1:0] row_sum;
   logic [CNT_W-1:0]        row_cnt;
   assign row_wl  = row[ROW_W-1 -: WL_W];
   assign row_sum = row[CNT_W +: SUM_W];
   assign row_cnt = row[CNT_W-1:0];

   // delta against the bank reference
   logic [TS_W-1:0]  diff;
   logic signed [TS_W:0] d_ext, mag;
   logic             outside;
   delta_type        d21, d_sat;
   assign diff    = ts_ff - ref_ff[bank_ff];
   assign d_ext   = {diff[TS_W-1], diff};
   assign mag     = d_ext[TS_W] ? -d_ext : d_ext;
   assign outside = mag >= $signed({{(TS_W+1-WIN_W){1'b0}}, window_ff});
   assign d21     = d_ext[D_W-1:0];
   assign d_sat   = (d_ext > $signed({{(TS_W+1-D_W){1'b0}}, D_MAX})) ? D_MAX :
                    (d_ext < $signed({{(TS_W+1-D_W){1'b1}}, D_MIN})) ? D_MIN : d21;

   // extreme sets from the ram row: largest ascending, smallest descending
   delta_type rmx [TRIM];
   delta_type rmn [TRIM];
   delta_type nmx [TRIM];
   delta_type nmn [TRIM];
   delta_type kept_c;
   logic      hit_mx, hit_mn;
   always_comb begin
      int p;
      int q;
      for (int j = 0; j < TRIM; j++) begin
         rmx[j] = set_rdata[j*D_W +: D_W];
         rmn[j] = set_rdata[(TRIM+j)*D_W +: D_W];
      end
      hit_mx = d21 > rmx[0];
      hit_mn = !hit_mx && (d21 < rmn[0]);
      p = 0;
      q = 0;
      for (int k = 1; k < TRIM; k++) begin
         if (rmx[k] < d21) p++;
         if (rmn[k] > d21) q++;
      end
      // drop the head and insert the new delta at its sorted place
      for (int j = 0; j < TRIM; j++) begin
         if (!hit_mx)     nmx[j] = rmx[j];
         else if (j < p)  nmx[j] = rmx[(j + 1 < TRIM) ? j + 1 : j];
         else if (j == p) nmx[j] = d21;
         else             nmx[j] = rmx[j];
         if (!hit_mn)     nmn[j] = rmn[j];
         else if (j < q)  nmn[j] = rmn[(j + 1 < TRIM) ? j + 1 : j];
         else if (j == q) nmn[j] = d21;
         else             nmn[j] = rmn[j];
      end
      kept_c = hit_mx ? rmx[0] : (hit_mn ? rmn[0] : d21);
   end

   // stable rank of the head of the warmup shift line
   int head_rank;
   always_comb begin
      head_rank = 0;
      for (int j = 0; j < WARMUP; j++) begin
         if (shv_ff[j] < shv_ff[0] || (shv_ff[j] == shv_ff[0] && shi_ff[j] < shi_ff[0]))
            head_rank++;
      end
      for (int j = 0; j < TRIM; j++) begin
         int tmx;
         int tmn;
         tmx = WARMUP - TRIM + j;
         if (tmx < 0) tmx = 0;
         tmn = TRIM - 1 - j;
         if (tmn > WARMUP - 1) tmn = WARMUP - 1;
         mx_in[j] = (head_rank == tmx) ? shv_ff[0] : mx_ff[j];
         mn_in[j] = (head_rank == tmn) ? shv_ff[0] : mn_ff[j];
      end
   end

   // divider step on magnitudes
   logic [REM_W-1:0] rem_sh;
   logic             take;
   assign rem_sh = {div_ff[REM_W+SUM_W-2 -: REM_W-1], div_ff[SUM_W-1]};
   assign take   = rem_sh >= {1'b0, cnt_ff};

   logic [SUM_W-1:0] sum_mag;
   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   logic signed [SUM_W-1:0] acc_sum;
   assign acc_sum = row_sum + SUM_W'(kept_c);

   // ram write data and addresses
   logic [WL_W-1:0] wl_dec;
   assign wl_dec = row_wl - WL_W'(1);

   always_comb begin
      slot_we     = 1'b0;
      slot_wdata  = row;
      set_we      = 1'b0;
      set_wdata   = set_rdata;
      store_we    = 1'b0;
      store_waddr = STORE_AW'(int'(slot_ff) * WARMUP + (WARMUP - int'(row_wl)));
      store_wdata = d21;
      store_raddr = STORE_AW'(int'(slot_ff) * WARMUP + int'(step_ff));
      if (state_ff == S_LOOK && armed_ff[slot_ff] && !outside) begin
         slot_we = 1'b1;
         if (row_wl != '0) begin
            store_we   = 1'b1;
            slot_wdata = {wl_dec, row_sum, row_cnt};
         end else begin
            set_we = 1'b1;
            for (int j = 0; j < TRIM; j++) begin
               set_wdata[j*D_W +: D_W]        = nmx[j];
               set_wdata[(TRIM+j)*D_W +: D_W] = nmn[j];
            end
            if (row_cnt < COUNT_MAX)
               slot_wdata = {row_wl, acc_sum, row_cnt + CNT_W'(1)};
         end
      end
      if (state_ff == S_RANK && int'(step_ff) == WARMUP - 1) begin
         set_we = 1'b1;
         for (int j = 0; j < TRIM; j++) begin
            set_wdata[j*D_W +: D_W]        = mx_in[j];
            set_wdata[(TRIM+j)*D_W +: D_W] = mn_in[j];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_fire) begin
            state_in = (req_kind == KIND_REF || !req_chan_ok) ? S_DONE : S_LOOK;
         end
         S_LOOK: begin
            if (armed_ff[slot_ff] && !outside && row_wl == WL_W'(1))
               state_in = S_LOAD;
            else
               state_in = S_DIV;
         end
         S_LOAD: if (int'(step_ff) == WARMUP) state_in = S_RANK;
         S_RANK: if (int'(step_ff) == WARMUP - 1) state_in = S_DIV;
         S_DIV:  if (int'(step_ff) == DIV_STEPS) state_in = S_DONE;
         S_DONE: if (!rsp_valid || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         window_ff  <= WINDOW_RESET;
         ref_ff[0]  <= '0;
         ref_ff[1]  <= '0;
         armed_ff   <= '0;
         touched_ff <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) window_ff <= csr_wr_data;
         // a held result stays valid, a done event always leaves one behind
         rsp_valid <= (state_ff == S_DONE) || (rsp_valid && !rsp_ready);
         case (state_ff)
            S_IDLE: if (req_fire && req_kind == KIND_REF) begin
               ref_ff[req_edge_req] <= req_timestamp_us;
               for (int c = 0; c < CHANNELS; c++)
                  armed_ff[SLOT_W'(int'(req_edge_req) * CHANNELS + c)] <= 1'b1;
            end
            S_LOOK: if (armed_ff[slot_ff]) begin
               armed_ff[slot_ff] <= 1'b0;
               if (!outside) touched_ff[slot_ff] <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            bank_ff  <= req_edge_req;
            slot_ff  <= req_slot;
            ts_ff    <= req_timestamp_us;
            status_ff <= (req_kind == KIND_REF) ? ST_ARMED : ST_NOARM;
            delta_ff <= '0;
            kept_ff  <= '0;
            mean_ff  <= '0;
            cnt_ff   <= '0;
         end
         S_LOOK: begin
            step_ff <= '0;
            if (armed_ff[slot_ff] && !outside && row_wl == '0 && row_cnt < COUNT_MAX) begin
               sum_ff <= acc_sum;
               cnt_ff <= row_cnt + CNT_W'(1);
            end else begin
               sum_ff <= row_sum;
               cnt_ff <= row_cnt;
            end
            if (armed_ff[slot_ff]) begin
               if (outside) begin
                  status_ff <= ST_OUTWIN;
                  delta_ff  <= d_sat;
               end else if (row_wl != '0) begin
                  status_ff <= ST_WARM;
                  delta_ff  <= d21;
               end else begin
                  delta_ff <= d21;
                  kept_ff  <= kept_c;
                  if (row_cnt >= COUNT_MAX)
                     status_ff <= ST_SAT;
                  else
                     status_ff <= ST_AVG;
               end
            end
         end
         S_LOAD: begin
            step_ff <= (int'(step_ff) == WARMUP) ? '0 : step_ff + STEP_W'(1);
            if (step_ff != '0) begin
               shv_ff[WARMUP-1] <= store_rdata;
               shi_ff[WARMUP-1] <= IDX_W'(int'(step_ff) - 1);
               for (int k = 0; k < WARMUP - 1; k++) begin
                  shv_ff[k] <= shv_ff[k+1];
                  shi_ff[k] <= shi_ff[k+1];
               end
            end
         end
         S_RANK: begin
            step_ff <= (int'(step_ff) == WARMUP - 1) ? '0 : step_ff + STEP_W'(1);
            for (int j = 0; j < TRIM; j++) begin
               mx_ff[j] <= mx_in[j];
               mn_ff[j] <= mn_in[j];
            end
            // rotate so every entry passes the head once
            shv_ff[WARMUP-1] <= shv_ff[0];
            shi_ff[WARMUP-1] <= shi_ff[0];
            for (int k = 0; k < WARMUP - 1; k++) begin
               shv_ff[k] <= shv_ff[k+1];
               shi_ff[k] <= shi_ff[k+1];
            end
         end
         S_DIV: begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == '0) begin
               div_ff <= {{REM_W{1'b0}}, sum_mag};
               neg_ff <= sum_ff[SUM_W-1];
            end else begin
               div_ff <= {(take ? rem_sh - {1'b0, cnt_ff} : rem_sh),
                          div_ff[SUM_W-2:0], take};
            end
         end
         S_DONE: ;
         default: ;
      endcase
      if (state_ff == S_DIV && int'(step_ff) == DIV_STEPS) begin
         // last quotient bit lands here
         if (cnt_ff == '0)
            mean_ff <= '0;
         else if (neg_ff)
            mean_ff <= -D_W'({div_ff[SUM_W-2:0], take});
         else
            mean_ff <= D_W'({div_ff[SUM_W-2:0], take});
      end
      if (state_ff == S_DONE && (!rsp_valid || rsp_ready)) begin
         rsp_status        <= status_ff;
         rsp_delta_us      <= delta_ff;
         rsp_kept_value_us <= kept_ff;
         rsp_mean_us       <= mean_ff;
         rsp_sample_count  <= cnt_ff;
      end
   end

   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid && !rsp_ready) |=> (state_ff == S_DONE))
      else $error("result overwritten while output stalled");

   // divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && step_ff != '0 && cnt_ff != '0)
         |-> (div_ff[REM_W+SUM_W-1 -: REM_W] < {1'b0, cnt_ff}))
      else $error("divider remainder out of range");

   // a looked-up channel is disarmed afterwards
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK) |=> !armed_ff[$past(slot_ff)])
      else $error("channel still armed after measurement");

endmodule

// ===== rtl/core/tla_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// depends on nothing
module tla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
